### rtl/core/vtp_pkg.sv
// vertex transform and projection: shared types, codes and the divider step
// no dependencies
package vtp_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned RegW   = 48;
  localparam int unsigned XyFrac = 8;
  localparam int unsigned DivW   = 32;

  typedef enum logic [1:0] {
    CFG_ROW_X  = 2'd0,
    CFG_ROW_Y  = 2'd1,
    CFG_ROW_Z  = 2'd2,
    CFG_TRANSL = 2'd3
  } cfg_index_e;

  // one stage of the restoring divider, both lanes share the divisor
  typedef struct packed {
    logic              valid;
    logic              last;
    logic              zero;
    logic              sign_x;
    logic              sign_y;
    logic              neg_x;
    logic              neg_y;
    logic [15:0]       dvs;
    logic [15:0]       rem_x;
    logic [DivW-1:0]   aq_x;
    logic [15:0]       rem_y;
    logic [DivW-1:0]   aq_y;
  } div_stage_t;

  typedef struct packed {
    logic [15:0]     rem;
    logic [DivW-1:0] aq;
  } div_lane_t;

  // one quotient bit: dividend bits shift out at the top, quotient bits in at the bottom
  function automatic div_lane_t div_step(logic [15:0] rem, logic [DivW-1:0] aq,
                                         logic [15:0] dvs);
    logic [16:0] t;
    logic [16:0] diff;
    div_lane_t   res;
    t    = {rem, aq[DivW-1]};
    diff = t - {1'b0, dvs};
    if (t >= {1'b0, dvs}) begin
      res.rem = diff[15:0];
      res.aq  = {aq[DivW-2:0], 1'b1};
    end else begin
      res.rem = t[15:0];
      res.aq  = {aq[DivW-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

### rtl/core/vertex_transform_project.sv
// vertex transform and perspective projection, fully pipelined
// depends on vtp_pkg
// pipeline from input transaction to result: 3 arithmetic stages, 32 divider
// stages at one quotient bit each, and one output stage
// throughput: one vertex per cycle; the whole pipeline holds when the output stalls
// reset clears all valid bits and the configuration registers to zero
// after a configuration write the correction terms are registered from the updated configuration registers
module vertex_transform_project import vtp_pkg::*; #(
  parameter int unsigned FRAC_BITS     = 12,
  parameter int unsigned SCREEN_WIDTH  = 256,
  parameter int unsigned SCREEN_HEIGHT = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [RegW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] vertex_x_i,
  input  logic signed [15:0] vertex_y_i,
  input  logic signed [15:0] vertex_z_i,
  input  logic               last_vertex_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] screen_x_o,
  output logic signed [15:0] screen_y_o,
  output logic               divide_fault_o,
  output logic               last_point_o
);

  localparam int unsigned Stages = DivW;
  localparam logic signed [17:0] HalfW = 18'(SCREEN_WIDTH / 2);
  localparam logic signed [17:0] HalfH = 18'(SCREEN_HEIGHT / 2);

  logic [RegW-1:0] coef_q [3];
  logic [RegW-1:0] transl_q;
  logic signed [32:0] corr_q [3];

  logic en;
  logic out_valid_q;

  assign cfg_ready_o = 1'b1;
  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0] <= '0;
      coef_q[1] <= '0;
      coef_q[2] <= '0;
      transl_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_ROW_X:  coef_q[0] <= cfg_data_i;
        CFG_ROW_Y:  coef_q[1] <= cfg_data_i;
        CFG_ROW_Z:  coef_q[2] <= cfg_data_i;
        CFG_TRANSL: transl_q  <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // stage 1: products
  logic               v1_q, last1_q;
  logic signed [33:0] p0_q [3];
  logic signed [31:0] p1_q [3];
  logic signed [31:0] xy_q;
  // stage 2: row sums
  logic               v2_q, last2_q;
  logic signed [35:0] rs_q [3];

  for (genvar r = 0; r < 3; r++) begin : g_row
    logic signed [15:0] m0, m1, m2, tl;
    logic signed [16:0] pa, pb;
    logic signed [31:0] mm;
    assign m0 = $signed(coef_q[r][15:0]);
    assign m1 = $signed(coef_q[r][31:16]);
    assign m2 = $signed(coef_q[r][47:32]);
    assign tl = $signed(transl_q[16*r +: 16]);
    assign pa = $signed({m0[15], m0}) + $signed({vertex_y_i[15], vertex_y_i});
    assign pb = $signed({m1[15], m1}) + $signed({vertex_x_i[15], vertex_x_i});
    assign mm = m0 * m1;

    always_ff @(posedge clk_i) begin
      corr_q[r] <= 33'(tl) - 33'(mm >>> FRAC_BITS);
      if (en) begin
        p0_q[r] <= pa * pb;
        p1_q[r] <= m2 * vertex_z_i;
        rs_q[r] <= 36'(p0_q[r]) + 36'(p1_q[r]) - 36'(xy_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xy_q    <= vertex_x_i * vertex_y_i;
      last1_q <= last_vertex_i;
      last2_q <= last1_q;
    end
  end

  // stage 3: scaling, correction, saturation and magnitudes
  logic signed [41:0] xp, yp, zp;
  logic signed [31:0] xc, yc;
  logic signed [15:0] zc;
  div_stage_t         st_d;
  div_stage_t         st_q [Stages+1];

  assign xp = 42'(rs_q[0] >>> (FRAC_BITS - XyFrac)) + (42'(corr_q[0]) <<< XyFrac);
  assign yp = 42'(rs_q[1] >>> (FRAC_BITS - XyFrac)) + (42'(corr_q[1]) <<< XyFrac);
  assign zp = 42'(rs_q[2] >>> FRAC_BITS) + 42'(corr_q[2]);

  always_comb begin
    if (xp > 42'sd2147483647)       xc = 32'sh7fffffff;
    else if (xp < -42'sd2147483648) xc = 32'sh80000000;
    else                            xc = xp[31:0];
    if (yp > 42'sd2147483647)       yc = 32'sh7fffffff;
    else if (yp < -42'sd2147483648) yc = 32'sh80000000;
    else                            yc = yp[31:0];
    if (zp > 42'sd32767)            zc = 16'sh7fff;
    else if (zp < -42'sd32768)      zc = 16'sh8000;
    else                            zc = zp[15:0];
    st_d.valid  = v2_q;
    st_d.last   = last2_q;
    st_d.zero   = (zc == 16'sd0);
    st_d.sign_x = xc[31];
    st_d.sign_y = yc[31];
    st_d.neg_x  = xc[31] ^ zc[15];
    st_d.neg_y  = yc[31] ^ zc[15];
    st_d.dvs    = zc[15] ? 16'(-zc) : zc;
    st_d.rem_x  = '0;
    st_d.aq_x   = xc[31] ? 32'(-xc) : xc;
    st_d.rem_y  = '0;
    st_d.aq_y   = yc[31] ? 32'(-yc) : yc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      st_q[0]  <= '0;
    end else if (en) begin
      v1_q     <= in_valid_i;
      v2_q     <= v1_q;
      st_q[0]  <= st_d;
    end
  end

  // divider: one quotient bit per stage
  for (genvar k = 1; k <= Stages; k++) begin : g_div
    div_lane_t  lx, ly;
    div_stage_t nxt;
    assign lx = div_step(st_q[k-1].rem_x, st_q[k-1].aq_x, st_q[k-1].dvs);
    assign ly = div_step(st_q[k-1].rem_y, st_q[k-1].aq_y, st_q[k-1].dvs);
    always_comb begin
      nxt       = st_q[k-1];
      nxt.rem_x = lx.rem;
      nxt.aq_x  = lx.aq;
      nxt.rem_y = ly.rem;
      nxt.aq_y  = ly.aq;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_q[k] <= '0;
      end else if (en) begin
        st_q[k] <= nxt;
      end
    end
  end

  // output stage: sign, saturation and screen offset
  div_stage_t         fin;
  logic signed [17:0] qx, qy, sx, sy;
  logic               fx, fy;
  logic signed [15:0] sx_d, sy_d;

  assign fin = st_q[Stages];

  always_comb begin
    fx = 1'b0;
    fy = 1'b0;
    priority if (fin.zero) begin
      fx = 1'b1;
      qx = fin.sign_x ? -18'sd32768 : 18'sd32767;
    end else if (fin.neg_x) begin
      if (fin.aq_x > 32'd32768) begin
        fx = 1'b1;
        qx = -18'sd32768;
      end else begin
        qx = -$signed({2'b00, fin.aq_x[15:0]});
      end
    end else begin
      if (fin.aq_x > 32'd32767) begin
        fx = 1'b1;
        qx = 18'sd32767;
      end else begin
        qx = $signed({2'b00, fin.aq_x[15:0]});
      end
    end
    priority if (fin.zero) begin
      fy = 1'b1;
      qy = fin.sign_y ? -18'sd32768 : 18'sd32767;
    end else if (fin.neg_y) begin
      if (fin.aq_y > 32'd32768) begin
        fy = 1'b1;
        qy = -18'sd32768;
      end else begin
        qy = -$signed({2'b00, fin.aq_y[15:0]});
      end
    end else begin
      if (fin.aq_y > 32'd32767) begin
        fy = 1'b1;
        qy = 18'sd32767;
      end else begin
        qy = $signed({2'b00, fin.aq_y[15:0]});
      end
    end
    sx = qx + HalfW;
    sy = qy + HalfH;
    if (sx > 18'sd32767)       sx_d = 16'sh7fff;
    else if (sx < -18'sd32768) sx_d = 16'sh8000;
    else                       sx_d = sx[15:0];
    if (sy > 18'sd32767)       sy_d = 16'sh7fff;
    else if (sy < -18'sd32768) sy_d = 16'sh8000;
    else                       sy_d = sy[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= fin.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      screen_x_o     <= sx_d;
      screen_y_o     <= sy_d;
      divide_fault_o <= fx | fy;
      last_point_o   <= fin.last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### sim/vertex_transform_project_tb.sv
// self-checking testbench for vertex_transform_project: table of directed vertices
// then random vertices, every result checked against a projection predictor; uses vtp_pkg
module vertex_transform_project_tb;
  import vtp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 20000;
  localparam int Latency = 40;

  typedef struct packed {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic               fault;
    logic               last;
  } point_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               last;
    logic               typed;
    point_t             pt;
  } vrow_t;

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [RegW-1:0] cfg_data_i;
  logic in_valid_i, in_ready_o;
  logic signed [15:0] vertex_x_i, vertex_y_i, vertex_z_i;
  logic last_vertex_i;
  logic out_valid_o, out_ready_i;
  logic signed [15:0] screen_x_o, screen_y_o;
  logic divide_fault_o, last_point_o;

  vertex_transform_project uut (.*);

  logic [RegW-1:0] coeff_reg [4];
  point_t pending_points[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_off = 0;
  bit in_done = 0;

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint lane(logic [RegW-1:0] r, int i);
    return longint'($signed(r[16*i +: 16]));
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // exact row sum in the pairwise-product form
  function automatic longint row_sum(logic [RegW-1:0] r, longint x, longint y, longint z);
    return (lane(r, 0) + y) * (lane(r, 1) + x) + lane(r, 2) * z - x * y;
  endfunction

  function automatic longint fixed_transl(logic [RegW-1:0] r, int i);
    return lane(coeff_reg[CFG_TRANSL], i) - ((lane(r, 0) * lane(r, 1)) >>> 12);
  endfunction

  function automatic longint quotient(longint a, longint b, ref bit fault);
    longint q;
    if (b == 0) begin
      fault = 1;
      return a < 0 ? -32768 : 32767;
    end
    q = a / b;
    if (q > 32767 || q < -32768) fault = 1;
    return clampl(q, -32768, 32767);
  endfunction

  function automatic point_t project(logic signed [15:0] vx, logic signed [15:0] vy,
                                     logic signed [15:0] vz, logic lst);
    longint x, y, z, xp, yp, zp;
    bit fault;
    point_t p;
    x = vx; y = vy; z = vz; fault = 0;
    xp = (row_sum(coeff_reg[CFG_ROW_X], x, y, z) >>> 4)
         + fixed_transl(coeff_reg[CFG_ROW_X], 0) * 256;
    yp = (row_sum(coeff_reg[CFG_ROW_Y], x, y, z) >>> 4)
         + fixed_transl(coeff_reg[CFG_ROW_Y], 1) * 256;
    zp = (row_sum(coeff_reg[CFG_ROW_Z], x, y, z) >>> 12)
         + fixed_transl(coeff_reg[CFG_ROW_Z], 2);
    xp = clampl(xp, -64'sd2147483648, 64'sd2147483647);
    yp = clampl(yp, -64'sd2147483648, 64'sd2147483647);
    zp = clampl(zp, -32768, 32767);
    p.sx = 16'(clampl(quotient(xp, zp, fault) + 128, -32768, 32767));
    p.sy = 16'(clampl(quotient(yp, zp, fault) + 128, -32768, 32767));
    p.fault = fault;
    p.last = lst;
    return p;
  endfunction

  task automatic write_reg(cfg_index_e idx, logic [RegW-1:0] d);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    coeff_reg[idx] = d;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
  endtask

  // valid stays high between back-to-back transactions; it drops for a gap or a drain
  task automatic send_vertex(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, logic lst, bit no_gap);
    if (!no_gap && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3))
        @(posedge clk_i);
    end
    in_valid_i <= 1;
    vertex_x_i <= x; vertex_y_i <= y; vertex_z_i <= z; last_vertex_i <= lst;
    do @(posedge clk_i); while (!in_ready_o);
    pending_points.push_back(project(x, y, z, lst));
  endtask

  function automatic logic [RegW-1:0] rand_row(int mode);
    logic [RegW-1:0] r;
    r = {$urandom, $urandom};
    if (mode == 1) r = {16'sd0, 16'sd4096, 16'sd0} ;
    return r;
  endfunction

  vrow_t dir_rows[$];

  // directed vertices, first with the all-zero rows and translation left by reset; typed rows are checked at once
  initial begin
    vrow_t r;
    int n;
    cfg_valid_i = 0; cfg_index_i = CFG_ROW_X; cfg_data_i = '0;
    in_valid_i = 0; vertex_x_i = 0; vertex_y_i = 0; vertex_z_i = 0; last_vertex_i = 0;
    rst_ni = 0;
    foreach (coeff_reg[i]) coeff_reg[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // after reset every row is zero: depth zero, dividend zero
    dir_rows = '{
      '{16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1, '{16'sd32767 + 16'sd0, 16'sd0, 1'b1, 1'b0}},
      '{16'sh7fff, 16'sh8000, 16'sh7fff, 1'b1, 1'b0, '0},
      '{16'sh8000, 16'sh7fff, 16'sh8000, 1'b0, 1'b0, '0}
    };
    // saturated offset: 32767 + 128 stays at 32767
    dir_rows[0].pt = '{16'sd32767, 16'sd32767, 1'b1, 1'b0};
    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      send_vertex(r.x, r.y, r.z, r.last, 1);
      if (r.typed && pending_points[$] != r.pt) begin
        $display("%0t: typed row %0d expected %h actual %h", $time, i, r.pt, pending_points[$]);
        errors++;
      end
    end
    drain();

    // identity transform with depth translation: extremes, zero depth, overflow
    write_reg(CFG_ROW_X, {16'sd0, 16'sd0, 16'sd4096});
    write_reg(CFG_ROW_Y, {16'sd0, 16'sd4096, 16'sd0});
    write_reg(CFG_ROW_Z, {16'sd4096, 16'sd0, 16'sd0});
    write_reg(CFG_TRANSL, {16'sd100, 16'sd0, 16'sd0});
    send_vertex(16'sd0, 16'sd0, -16'sd100, 0, 1);
    send_vertex(16'sh7fff, 16'sh8000, -16'sd100, 0, 1);
    send_vertex(16'sh8000, 16'sh7fff, -16'sd99, 0, 1);
    send_vertex(16'sd1000, -16'sd1000, 16'sd0, 0, 1);
    send_vertex(-16'sd5, 16'sd5, 16'sd1, 0, 1);
    send_vertex(16'sd7, -16'sd7, -16'sd200, 1, 1);
    send_vertex(16'sh5555, 16'shaaaa, 16'sh5555, 0, 1);
    send_vertex(16'shaaaa, 16'sh5555, 16'shaaaa, 1, 1);
    drain();
    // extreme coefficients and translations: rows of the most negative or the most positive value
    write_reg(CFG_ROW_X, {3{16'sh8000}});
    write_reg(CFG_ROW_Y, {3{16'sh7fff}});
    write_reg(CFG_ROW_Z, {3{16'sh8000}});
    write_reg(CFG_TRANSL, {16'sh7fff, 16'sh8000, 16'sh7fff});
    send_vertex(16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 1);
    send_vertex(16'sh8000, 16'sh8000, 16'sh8000, 1, 1);
    send_vertex(16'sd0, 16'sd0, 16'sd0, 0, 1);
    drain();

    // random phases
    n = 0;
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_ROW_X, ph % 2 ? rand_row(0) : {16'($urandom_range(0, 800)) - 16'sd400,
                16'sd0, 16'sd4096});
      write_reg(CFG_ROW_Y, ph % 2 ? rand_row(0) : rand_row(1));
      write_reg(CFG_ROW_Z, ph % 2 ? rand_row(0) : {16'sd4096, 16'($urandom_range(0, 300)), 16'sd0});
      write_reg(CFG_TRANSL, ph % 2 ? rand_row(0) : {16'($urandom_range(0, 2000)), 16'($urandom),
                16'($urandom)});
      if (ph == 3) begin
        hold_off = 1;
        for (int i = 0; i < 60; i++)
          send_vertex(16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom), 1);
        n += 60;
      end
      for (int i = 0; i < 225; i++) begin
        int s;
        s = $urandom_range(0, 3);
        // small coordinates keep depth sane most of the time
        if (s == 0)
          send_vertex(16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom), 0);
        else
          send_vertex(16'($urandom_range(0, 400)) - 16'sd200, 16'($urandom_range(0, 400)) - 16'sd200,
                      16'($urandom_range(0, 4000)), 1'($urandom), i % 50 < 10);
        n++;
      end
      drain();
    end
    in_done = 1;
  end

  // receiver with random stalls and one long hold-off
  initial begin
    out_ready_i = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_ready_i <= 0;
        repeat (150) @(posedge clk_i);
        hold_off = 0;
      end else if ($urandom_range(0, 30) == 0) begin
        out_ready_i <= 0;
        repeat ($urandom_range(5, 40)) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(0, 99) < 75) ? 1'b1 :
                       ($urandom_range(0, 9) == 0 ? 1'b0 : 1'b1);
      end
    end
  end

  // result checking and watchdog
  always @(posedge clk_i) begin
    point_t got, want;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (out_valid_o && out_ready_i) begin
        got = '{screen_x_o, screen_y_o, divide_fault_o, last_point_o};
        if (pending_points.size() == 0) begin
          $display("%0t: unexpected result actual %h", $time, got);
          errors++;
        end else begin
          want = pending_points.pop_front();
          if (got.sx !== want.sx) begin
            $display("%0t: screen_x expected %0d actual %0d", $time, want.sx, got.sx);
            errors++;
          end
          if (got.sy !== want.sy) begin
            $display("%0t: screen_y expected %0d actual %0d", $time, want.sy, got.sy);
            errors++;
          end
          if (got.fault !== want.fault) begin
            $display("%0t: divide_fault expected %b actual %b", $time, want.fault, got.fault);
            errors++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last_point expected %b actual %b", $time, want.last, got.last);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    wait (in_done || idle_cycles >= WatchdogLimit);
    if (in_done) begin
      if (errors == 0 && pending_points.size() == 0)
        $display("SUCCESS");
      else
        $display("FAILURE");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
